// ===== src/tcw_pkg.sv =====
// Text console writer: shared constants, codes and types.
// Used by text_console_writer_core, tcw_screen_ram and tcw_checker.
// No dependencies.
package tcw_pkg;

   // Screen geometry
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int TERMINALS      = 4;
   localparam int TAB_STOP       = 8;
   localparam int PAGE_CELLS     = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int CELLS          = TERMINALS * PAGE_CELLS;
   localparam int ADDR_W         = $clog2(CELLS);

   // Field widths
   localparam int OP_W      = 3;
   localparam int TERM_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int COLOR_W   = 8;
   localparam int POS_W     = 11;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int OFFS_W    = 16;
   localparam int CELL_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   // Stream packing
   localparam int REQ_USER_W = OP_W + TERM_W;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_POS_LSB    = OFFS_W;
   localparam int RSP_SCROLL_BIT = RSP_POS_LSB + POS_W;
   localparam int RSP_CELL_LSB   = RSP_SCROLL_BIT + 1;
   localparam int RSP_USED_W     = RSP_CELL_LSB + CELL_W;

   // Character codes
   localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0]  CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
   localparam logic [CELL_W-1:0]  RESET_BLANK  = {RESET_COLOR, BLANK_CHAR};

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUT     = 3'd0,
      OP_SET_POS = 3'd1,
      OP_SET_CR  = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_READ    = 3'd4
   } op_type;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_TERM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_OFF  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_COLOR = 2'd2;

   // Screen store access: one write and one read per cycle
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

// ===== src/tcw_screen_ram.sv =====
// Screen cell store for all terminals: one write port, one registered read port.
// Depends on tcw_pkg.
module tcw_screen_ram (
   input  logic                 clock,
   input  tcw_pkg::ram_req_type ram_req,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [0:CELLS-1];
   logic [CELL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/text_console_writer_core.sv =====
// Text console writer: top level, request sequencer and cursor state.
// Depends on tcw_pkg and tcw_screen_ram.
//
//   Channel   Direction  Handshake              Contents
//   req_      in         tvalid/tready          tuser: operation, terminal
//                                               tdata: character, color, position,
//                                                      column, row
//   rsp_      out        tvalid/tready          tuser: cursor_update
//                                               tdata: cursor_value, new_position,
//                                                      scrolled, cell_value
//   csr_      in         we (no back-pressure)  index, wdata
//
// Set position, set column row, spare codes and reads past the screen go from
// execute straight to the response; tab, backspace and plain characters pass the
// wrap check, read cell passes the read state, and newline first steps row by row
// to the start of the next row. A roll-up copies, then blanks the bottom line; it
// and clear are both bound by the single write port of the store. After reset the
// store is blanked one cell a cycle with req_tready low. A result waiting on rsp_tready
// does not block the next request until that request has its own result ready.
module text_console_writer_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tcw_pkg::REQ_USER_W-1:0]     req_tuser,  // operation[2:0], terminal[4:3]
   input  logic [tcw_pkg::REQ_DATA_W-1:0]     req_tdata,  // character[7:0], color[15:8],
                                                          // position[26:16], column[33:27],
                                                          // row[38:34]
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_tuser,  // cursor_update
   output logic [tcw_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // cursor_value[15:0],
                                                          // new_position[26:16],
                                                          // scrolled[27], cell_value[43:28]
   // control registers
   input  logic                               csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcw_pkg::CSR_W-1:0]          csr_wdata
);
   import tcw_pkg::*;

   typedef enum logic [8:0] {
      ST_INIT    = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_EXEC    = 9'b000000100,
      ST_NEWLINE = 9'b000001000,
      ST_WRAP    = 9'b000010000,
      ST_COPY    = 9'b000100000,
      ST_FILL    = 9'b001000000,
      ST_READ    = 9'b010000000,
      ST_RESP    = 9'b100000000
   } state_type;

   localparam int                TERM_N     = 1 << TERM_W;
   localparam logic [POS_W-1:0]  SIZE_P     = POS_W'(PAGE_CELLS);
   localparam logic [POS_W-1:0]  LAST_P     = POS_W'(PAGE_CELLS - 1);
   localparam logic [POS_W-1:0]  COLS_P     = POS_W'(SCREEN_COLUMNS);
   localparam logic [POS_W-1:0]  COPY_N     = POS_W'(PAGE_CELLS - SCREEN_COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] SCR_LAST_A = ADDR_W'(PAGE_CELLS - 1);
   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLUMNS);

   // control state
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [TERM_W-1:0]  cur_term_ff;
   logic [OFFS_W-1:0]  disp_off_ff;
   logic [COLOR_W-1:0] def_color_ff;
   logic [POS_W-1:0]   cursor_ff [0:TERM_N-1];
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   // request context and working registers
   op_type             op_ff, op_in;
   logic [TERM_W-1:0]  term_ff, term_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   acc_ff, acc_in;
   logic [POS_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic               scrolled_ff, scrolled_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic               rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // helpers
   ram_req_type        ram_req;
   logic [CELL_W-1:0]  rd_data;
   logic [CELL_W-1:0]  blank;
   logic               term_ok;
   logic               moves;
   logic               upd;
   logic               rsp_load;
   logic [POS_W:0]     nl_sum;
   logic [POS_W:0]     cr_idx;
   logic [POS_W-1:0]   tab_pos;
   logic [ADDR_W-1:0]  cur_addr;

   tcw_screen_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign blank    = {def_color_ff, BLANK_CHAR};
   assign term_ok  = int'(term_ff) < TERMINALS;
   assign nl_sum   = {1'b0, acc_ff} + {1'b0, COLS_P};
   assign cr_idx   = (POS_W + 1)'(row_ff) * (POS_W + 1)'(SCREEN_COLUMNS)
                     + (POS_W + 1)'(column_ff);
   assign tab_pos  = POS_W'((int'(pos_ff) / TAB_STOP + 1) * TAB_STOP);
   assign cur_addr = base_ff + ADDR_W'(pos_ff);
   assign moves    = (op_ff == OP_PUT) || (op_ff == OP_SET_POS) ||
                     (op_ff == OP_SET_CR) || (op_ff == OP_CLEAR);
   assign upd      = moves && term_ok && (term_ff == cur_term_ff);
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_pend_in   = rd_pend_ff;
      op_in        = op_ff;
      term_in      = term_ff;
      char_in      = char_ff;
      color_in     = color_ff;
      position_in  = position_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      last_in      = last_ff;
      scrolled_in  = scrolled_ff;
      cell_in      = cell_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_req      = '0;

      case (state_ff)
         // blank every cell of every terminal after reset
         ST_INIT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = addr_ff;
            ram_req.wr_data = RESET_BLANK;
            if (addr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_tvalid) begin
               op_in       = op_type'(req_tuser[OP_W-1:0]);
               term_in     = req_tuser[OP_W +: TERM_W];
               char_in     = req_tdata[7:0];
               color_in    = req_tdata[15:8];
               position_in = req_tdata[26:16];
               column_in   = req_tdata[33:27];
               row_in      = req_tdata[38:34];
               pos_in      = cursor_ff[req_tuser[OP_W +: TERM_W]];
               base_in     = ADDR_W'(req_tuser[OP_W +: TERM_W]) * ADDR_W'(PAGE_CELLS);
               scrolled_in = 1'b0;
               cell_in     = '0;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_RESP;
            if (term_ok) begin
               case (op_ff)
                  OP_PUT: begin
                     state_in = ST_WRAP;
                     case (char_ff)
                        CH_NEWLINE: begin
                           acc_in   = '0;
                           state_in = ST_NEWLINE;
                        end
                        CH_TAB: begin
                           pos_in = tab_pos;
                        end
                        CH_BACKSPACE: begin
                           if (pos_ff != '0) begin
                              pos_in          = pos_ff - 1'b1;
                              ram_req.wr_en   = 1'b1;
                              ram_req.wr_addr = cur_addr - 1'b1;
                              ram_req.wr_data = blank;
                           end
                        end
                        default: begin
                           pos_in          = pos_ff + 1'b1;
                           ram_req.wr_en   = 1'b1;
                           ram_req.wr_addr = cur_addr;
                           ram_req.wr_data = {color_ff, char_ff};
                        end
                     endcase
                  end
                  OP_SET_POS: begin
                     pos_in = (position_ff < SIZE_P) ? position_ff : LAST_P;
                  end
                  OP_SET_CR: begin
                     pos_in = (cr_idx < (POS_W + 1)'(PAGE_CELLS)) ? cr_idx[POS_W-1:0]
                                                                   : LAST_P;
                  end
                  OP_CLEAR: begin
                     addr_in  = base_ff;
                     last_in  = base_ff + SCR_LAST_A;
                     state_in = ST_FILL;
                  end
                  OP_READ: begin
                     if (position_ff < SIZE_P) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = base_ff + ADDR_W'(position_ff);
                        state_in        = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // find the start of the row below the cursor by repeated addition
         ST_NEWLINE: begin
            if (nl_sum <= {1'b0, pos_ff}) begin
               acc_in = nl_sum[POS_W-1:0];
            end else begin
               pos_in   = nl_sum[POS_W-1:0];
               state_in = ST_WRAP;
            end
         end

         ST_WRAP: begin
            if (pos_ff >= SIZE_P) begin
               rd_ptr_in  = base_ff + COLS_A;
               wr_ptr_in  = base_ff;
               cnt_in     = '0;
               rd_pend_in = 1'b0;
               state_in   = ST_COPY;
            end else begin
               state_in = ST_RESP;
            end
         end

         // move every line up by one: read one row ahead, write the cell just read
         ST_COPY: begin
            rd_pend_in = 1'b0;
            if (cnt_ff != COPY_N) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = rd_ptr_ff;
               rd_ptr_in       = rd_ptr_ff + 1'b1;
               cnt_in          = cnt_ff + 1'b1;
               rd_pend_in      = 1'b1;
            end
            if (rd_pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = wr_ptr_ff;
               ram_req.wr_data = rd_data;
               wr_ptr_in       = wr_ptr_ff + 1'b1;
            end
            if ((cnt_ff == COPY_N) && !rd_pend_ff) begin
               addr_in  = wr_ptr_ff;
               last_in  = base_ff + SCR_LAST_A;
               state_in = ST_FILL;
            end
         end

         // blank a run of cells: whole screen for clear, bottom line after roll-up
         ST_FILL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = addr_ff;
            ram_req.wr_data = blank;
            if (addr_ff == last_ff) begin
               if (op_ff == OP_CLEAR) begin
                  pos_in   = '0;
                  state_in = ST_RESP;
               end else begin
                  pos_in      = pos_ff - COLS_P;
                  scrolled_in = 1'b1;
                  state_in    = ST_WRAP;
               end
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_READ: begin
            cell_in  = rd_data;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = upd;
               rsp_data_in  = RSP_DATA_W'({cell_ff,
                                           scrolled_ff & term_ok,
                                           term_ok ? pos_ff : {POS_W{1'b0}},
                                           upd ? disp_off_ff + OFFS_W'(pos_ff)
                                               : {OFFS_W{1'b0}}});
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         cur_term_ff  <= '0;
         disp_off_ff  <= '0;
         def_color_ff <= RESET_COLOR;
         for (int i = 0; i < TERM_N; i++) begin
            cursor_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CUR_TERM:  cur_term_ff  <= csr_wdata[TERM_W-1:0];
               CSR_DISP_OFF:  disp_off_ff  <= csr_wdata[OFFS_W-1:0];
               CSR_DEF_COLOR: def_color_ff <= csr_wdata[COLOR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load && term_ok) begin
            cursor_ff[term_ff] <= pos_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      term_ff     <= term_in;
      char_ff     <= char_in;
      color_ff    <= color_in;
      position_ff <= position_in;
      column_ff   <= column_in;
      row_ff      <= row_in;
      base_ff     <= base_in;
      pos_ff      <= pos_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      last_ff     <= last_in;
      scrolled_ff <= scrolled_in;
      cell_ff     <= cell_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/tcw_checker.sv =====
// Port-level checks for text_console_writer_core, attached by bind.
// Depends on tcw_pkg.
module tcw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic                           rsp_tuser,
   input logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tcw_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // ready and valid are low just after reset, while the store is being blanked
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ready or valid straight after reset");

   // no cursor write means a zero cursor value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[OFFS_W-1:0] == '0)
      else $error("cursor value without cursor update");

   // cursor always ends on screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_POS_LSB +: POS_W] < POS_W'(PAGE_CELLS))
      else $error("cursor past end of screen");

   // a roll-up and a cell read never share a response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_SCROLL_BIT] |-> rsp_tdata[RSP_CELL_LSB +: CELL_W] == '0)
      else $error("cell value on a scrolled response");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
